FILE: rtl/core/buddy_block_allocator_assert.svh
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bba_pkg.sv
// shared types and codes for the buddy block allocator
`default_nettype none
package bba_pkg;
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_QFULL = 2'd2;

  localparam int REQ_W = 19;
  localparam int ALIGN_W = 17;
  localparam int AOFF_W = 18;
  localparam int USED_W = 19;
  localparam int ORD_W = 5;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ALIGN_DIV,
    S_SIZE,
    S_ORDER,
    S_CHECK,
    S_SCAN,
    S_SCAN_RD,
    S_SCAN_WAIT,
    S_SPLIT,
    S_OFF_DIV,
    S_OFF_FIX,
    S_FL_START,
    S_FL_RD,
    S_FL_WAIT,
    S_FL_ENTRY,
    S_MERGE_RD,
    S_MERGE_WAIT,
    S_MERGE,
    S_FL_NEXT,
    S_DONE
  } state_t;

  // interface to the shared divider
  typedef struct packed {
    logic        start;
    logic [36:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [36:0] quot;
    logic [16:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/bba_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/bba_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module bba_div
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [36:0] quot;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_r;
  logic [17:0] trial;
  logic [17:0] sh;

  assign sh = {rem[16:0], quot[36]};
  assign trial = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd37;
        quot <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          quot <= {quot[35:0], 1'b1};
        end else begin
          rem <= sh;
          quot <= {quot[35:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot;
  assign rsp.rem = rem[16:0];
endmodule
`default_nettype wire

FILE: rtl/core/buddy_block_allocator.sv
// buddy block allocator top level
// Commands are taken when start is high and busy is low; each command yields exactly one
// result, shown for one cycle with done high, and the receiver cannot stall it. Busy stays
// high for the whole command. An allocate runs the alignment check on the one-bit-per-cycle
// divider, the order search, a scan of the free map one node at a time and the splits,
// plus an alignment round-up on the divider when an alignment is given. A release
// queues its entry, or reports ST_QFULL when the queue is full. A flush walks the queued
// entries and merges each with its free buddies level by level. After reset, a clearing
// pass writes every free-map entry before the first command is taken.
`default_nettype none
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MIN_BLOCK_BYTES = 256,
  parameter int MAX_ORDER = 10,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      done,
  input  wire logic [1:0]           operation,
  input  wire logic [REQ_W-1:0]     request_bytes,
  input  wire logic [ALIGN_W-1:0]   align_bytes,
  input  wire logic [9:0]           release_offset,
  input  wire logic [3:0]           release_order,
  output logic      [1:0]           status,
  output logic      [9:0]           block_offset_out,
  output logic      [3:0]           block_order_out,
  output logic      [AOFF_W-1:0]    aligned_byte_offset,
  output logic      [USED_W-1:0]    bytes_in_use
);
  localparam int MAP_SIZE = (2 << MAX_ORDER) - 1;
  localparam int MAP_AW = $clog2(MAP_SIZE + 1);
  localparam int UNIT_W = MAX_ORDER;
  localparam int MINB_W = $clog2(MIN_BLOCK_BYTES);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QDW = 14;
  localparam logic [36:0] POOL_BYTES = 37'(MIN_BLOCK_BYTES) << MAX_ORDER;
  localparam logic [ORD_W-1:0] MAXO = ORD_W'(MAX_ORDER);

  state_t state, state_next;

  // request registers
  logic [1:0]  op;
  logic [REQ_W-1:0] req;
  logic [ALIGN_W-1:0] algn;
  logic [9:0]  rel_off;
  logic [3:0]  rel_ord;

  logic [USED_W-1:0] used;
  logic [QCW-1:0]    qcount;
  logic [QCW-1:0]    qidx;

  // allocate working registers
  logic [36:0] size;
  logic [36:0] units;
  logic [ORD_W-1:0] ord;
  logic [ORD_W-1:0] j;
  logic [UNIT_W:0]  scan_i;
  logic [UNIT_W-1:0] off;
  logic [36:0] byte_off;
  logic [1:0]  res_status;
  logic [AOFF_W-1:0] res_aligned;

  // flush working registers
  logic [UNIT_W-1:0] f_off;
  logic [ORD_W-1:0] f_ord;
  logic [36:0] f_sz;

  // clear pass
  logic        clearing;
  logic [MAP_AW-1:0] clr_addr;

  // free map ram
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic              map_wdata, map_rdata;

  // queue ram
  logic              q_we;
  logic [QDW-1:0]    q_rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  function automatic logic [MAP_AW-1:0] node_at(input logic [ORD_W-1:0] o,
                                                input logic [UNIT_W-1:0] u);
    logic [MAP_AW-1:0] base;
    logic [MAP_AW-1:0] rel;
    base = MAP_AW'((MAP_AW'(1) << (MAXO - o)) - MAP_AW'(1));
    rel = MAP_AW'({1'b0, u} >> o);
    return base + rel;
  endfunction

  bba_ram #(.WIDTH(1), .DEPTH(MAP_SIZE + 1)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  bba_ram #(.WIDTH(QDW), .DEPTH(1 << QAW)) u_queue (
    .clk(clk), .we(q_we), .waddr(qcount[QAW-1:0]), .wdata({rel_off, rel_ord}),
    .raddr(qidx[QAW-1:0]), .rdata(q_rdata)
  );

  bba_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // padded size, valid while the alignment check result is shown
  assign size = {18'd0, req} + ((algn != '0 && drsp.rem != '0) ? 37'(algn) : 37'd0);

  assign busy = clearing || (state != S_IDLE);
  assign q_we = (state == S_ALIGN_DIV) && (op == OP_RELEASE) && (qcount < QCW'(QUEUE_DEPTH));

  logic [UNIT_W-1:0] lin_off;
  logic [MAP_AW-1:0] scan_node;
  assign lin_off = UNIT_W'({1'b0, scan_i[UNIT_W-1:0]} << j);
  assign scan_node = node_at(j, lin_off);

  logic [UNIT_W-1:0] q_off_m;
  assign q_off_m = UNIT_W'(q_rdata[13:4]) &
                   ~UNIT_W'((({UNIT_W{1'b0}} | UNIT_W'(1)) << q_rdata[3:0]) - UNIT_W'(1));
  logic [UNIT_W-1:0] f_buddy;
  assign f_buddy = f_off ^ UNIT_W'(UNIT_W'(1) << f_ord);

  // split target
  logic [ORD_W-1:0] jm1;
  assign jm1 = j - ORD_W'(1);

  always_comb begin
    state_next = state;
    map_we = 1'b0;
    map_waddr = '0;
    map_wdata = 1'b0;
    map_raddr = '0;
    dreq.start = 1'b0;
    dreq.dividend = '0;
    dreq.divisor = algn;
    if (clearing) begin
      map_we = 1'b1;
      map_waddr = clr_addr;
      map_wdata = (clr_addr == '0);
    end
    case (state)
      S_IDLE: begin
        if (start && !clearing) begin
          state_next = S_ALIGN_DIV;
        end
      end
      S_ALIGN_DIV: begin
        if (op == OP_ALLOC) begin
          dreq.start = 1'b1;
          dreq.dividend = 37'(MIN_BLOCK_BYTES);
          state_next = S_SIZE;
        end else if (op == OP_FLUSH) begin
          state_next = S_FL_START;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SIZE: begin
        if (drsp.done) state_next = S_ORDER;
      end
      S_ORDER: begin
        if (ord > MAXO || (37'(1) << ord) >= units)
          state_next = S_CHECK;
      end
      S_CHECK: begin
        if (ord > MAXO || {18'd0, used} == POOL_BYTES) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (j > MAXO) state_next = S_DONE;
        else begin
          map_raddr = scan_node;
          state_next = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        map_raddr = scan_node;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (map_rdata) begin
          map_we = 1'b1;
          map_waddr = scan_node;
          map_wdata = 1'b0;
          state_next = S_SPLIT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SPLIT: begin
        if (j > ord) begin
          map_we = 1'b1;
          map_waddr = node_at(jm1, off + UNIT_W'(UNIT_W'(1) << jm1));
          map_wdata = 1'b1;
        end else if (algn != '0) begin
          dreq.start = 1'b1;
          dreq.dividend = byte_off;
          state_next = S_OFF_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_OFF_DIV: begin
        if (drsp.done) state_next = S_OFF_FIX;
      end
      S_OFF_FIX: state_next = S_DONE;
      S_FL_START: begin
        if (qidx >= qcount) state_next = S_DONE;
        else state_next = S_FL_RD;
      end
      S_FL_RD: state_next = S_FL_WAIT;
      S_FL_WAIT: state_next = S_FL_ENTRY;
      S_FL_ENTRY: begin
        if (q_rdata[3:0] > MAX_ORDER[3:0] && MAX_ORDER < 16) state_next = S_FL_NEXT;
        else state_next = S_MERGE_RD;
      end
      S_MERGE_RD: begin
        map_raddr = node_at(f_ord, f_buddy);
        if (f_ord >= MAXO) begin
          map_we = 1'b1;
          map_waddr = node_at(f_ord, f_off);
          map_wdata = 1'b1;
          state_next = S_FL_NEXT;
        end else begin
          state_next = S_MERGE_WAIT;
        end
      end
      S_MERGE_WAIT: begin
        map_raddr = node_at(f_ord, f_buddy);
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (map_rdata) begin
          map_we = 1'b1;
          map_waddr = node_at(f_ord, f_buddy);
          map_wdata = 1'b0;
          state_next = S_MERGE_RD;
        end else begin
          map_we = 1'b1;
          map_waddr = node_at(f_ord, f_off);
          map_wdata = 1'b1;
          state_next = S_FL_NEXT;
        end
      end
      S_FL_NEXT: state_next = S_FL_START;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [36:0] nu;
  assign nu = {18'd0, used} + (37'(MIN_BLOCK_BYTES) << ord);

  logic [36:0] units_raw;
  assign units_raw = (size + 37'(MIN_BLOCK_BYTES - 1)) >> MINB_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      used <= '0;
      qcount <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (clearing) begin
        clr_addr <= clr_addr + MAP_AW'(1);
        if (clr_addr == MAP_AW'(MAP_SIZE)) clearing <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start && !clearing) begin
            op <= operation;
            req <= request_bytes;
            algn <= align_bytes;
            rel_off <= release_offset;
            rel_ord <= release_order;
            res_status <= ST_OK;
            res_aligned <= '0;
            off <= '0;
            ord <= '0;
            qidx <= '0;
          end
        end
        S_ALIGN_DIV: begin
          if (op == OP_RELEASE) begin
            if (qcount < QCW'(QUEUE_DEPTH)) qcount <= qcount + QCW'(1);
            else res_status <= ST_QFULL;
          end
        end
        S_SIZE: begin
          if (drsp.done) begin
            units <= (units_raw == '0) ? 37'd1 : units_raw;
          end
        end
        S_ORDER: begin
          if (!(ord > MAXO || (37'(1) << ord) >= units)) ord <= ord + ORD_W'(1);
        end
        S_CHECK: begin
          j <= ord;
          scan_i <= '0;
          if (ord > MAXO || {18'd0, used} == POOL_BYTES) res_status <= ST_NOSPACE;
        end
        S_SCAN: begin
          if (j > MAXO) res_status <= ST_NOSPACE;
        end
        S_SCAN_RD: begin
          if (map_rdata) begin
            off <= lin_off;
            byte_off <= 37'(lin_off) << MINB_W;
          end else if (scan_i == ((UNIT_W+1)'(1) << (MAXO - j)) - (UNIT_W+1)'(1)) begin
            scan_i <= '0;
            j <= j + ORD_W'(1);
          end else begin
            scan_i <= scan_i + (UNIT_W+1)'(1);
          end
        end
        S_SPLIT: begin
          if (j > ord) j <= jm1;
          else begin
            used <= (nu > 37'h7FFFF) ? USED_W'(19'h7FFFF) : USED_W'(nu);
            res_aligned <= AOFF_W'(byte_off);
          end
        end
        S_OFF_FIX: begin
          if (drsp.rem != '0)
            res_aligned <= (drsp.quot[AOFF_W-1:0] + AOFF_W'(1)) * AOFF_W'(algn);
        end
        S_FL_ENTRY: begin
          f_off <= q_off_m;
          f_ord <= ORD_W'(q_rdata[3:0]);
          // skipped entries leave the byte count alone
          if (q_rdata[3:0] > MAX_ORDER[3:0] && MAX_ORDER < 16) f_sz <= '0;
          else f_sz <= 37'(MIN_BLOCK_BYTES) << q_rdata[3:0];
        end
        S_MERGE: begin
          if (map_rdata) begin
            f_off <= f_off & ~UNIT_W'(UNIT_W'(1) << f_ord);
            f_ord <= f_ord + ORD_W'(1);
          end
        end
        S_FL_NEXT: begin
          used <= (f_sz >= {18'd0, used}) ? '0 : USED_W'({18'd0, used} - f_sz);
          qidx <= qidx + QCW'(1);
        end
        S_DONE: begin
          if (op == OP_FLUSH) qcount <= '0;
          status <= res_status;
          block_offset_out <= (res_status == ST_OK && op == OP_ALLOC) ? 10'(off) : '0;
          block_order_out <= (res_status == ST_OK && op == OP_ALLOC) ? 4'(ord) : '0;
          aligned_byte_offset <= (res_status == ST_OK && op == OP_ALLOC) ? res_aligned : '0;
          bytes_in_use <= used;
        end
        default: ;
      endcase
    end
  end

  // entries at an order above MAX_ORDER must be skipped before the merge
  `include "buddy_block_allocator_assert.svh"

  `BBA_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held for more than one cycle")
  `BBA_ASSERT_IMPL(a_no_start_clear, clk, rst, clearing, state == S_IDLE, "command during clear")
  `BBA_ASSERT_IMPL(a_qcount_max, clk, rst, 1'b1, qcount <= QCW'(QUEUE_DEPTH), "queue overflow")
endmodule
`default_nettype wire
